// ===== rtl/core/orl_pkg.sv =====
// orl_pkg: shared types and codes for the ordered record list
// item and result payloads, command codes, status codes, controller/datapath links
// no dependencies
package orl_pkg;

  localparam logic [2:0] CMD_APPEND = 3'd0;
  localparam logic [2:0] CMD_DELETE = 3'd1;
  localparam logic [2:0] CMD_CLEAR  = 3'd2;
  localparam logic [2:0] CMD_COUNT  = 3'd3;
  localparam logic [2:0] CMD_KTH    = 3'd4;
  localparam logic [2:0] CMD_MIDDLE = 3'd5;
  localparam logic [2:0] CMD_VIEW   = 3'd6;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_EMPTY     = 3'd3;
  localparam logic [2:0] ST_BAD_POS   = 3'd4;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] key;
    logic [15:0]        height_in;
    logic [4:0]         from_end;
  } item_t;

  typedef struct packed {
    logic signed [31:0] rec_key;
    logic [15:0]        rec_height;
    logic [3:0]         rec_index;
    logic [4:0]         list_count;
    logic [2:0]         status;
    logic               last;
  } result_t;

  typedef enum logic [2:0] {
    RD_ZERO = 3'd0,
    RD_KTH  = 3'd1,
    RD_MID  = 3'd2,
    RD_PTR1 = 3'd3,
    RD_PTR2 = 3'd4
  } rd_sel_t;

  typedef enum logic [1:0] {
    PTR_HOLD = 2'd0,
    PTR_LOAD = 2'd1,
    PTR_INC  = 2'd2
  } ptr_op_t;

  typedef enum logic [2:0] {
    EM_NONE   = 3'd0,
    EM_BLANK  = 3'd1,
    EM_NEW    = 3'd2,
    EM_READ   = 3'd3,
    EM_SAVE   = 3'd4,
    EM_FINISH = 3'd5
  } emit_t;

  typedef struct packed {
    logic       capture;
    logic       write_tail;
    logic       shift_wr;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       cnt_clr;
    rd_sel_t    rd_sel;
    ptr_op_t    ptr_op;
    emit_t      emit;
    logic [2:0] status;
    logic       last;
  } dp_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic full;
    logic match;
    logic ptr_last;
    logic ptr_next_last;
  } dp_stat_t;

endpackage

// ===== rtl/core/orl_datapath.sv =====
// orl_datapath: record memories, entry count, scan pointer and result register
// driven by orl_ctrl through orl_pkg::dp_cmd_t, reports orl_pkg::dp_stat_t
// depends on orl_pkg
module orl_datapath #(
  parameter int DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  orl_pkg::item_t   item,
  input  orl_pkg::dp_cmd_t dc,
  output orl_pkg::dp_stat_t st,
  output logic             result_valid,
  output orl_pkg::result_t result
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int KW    = (CNT_W > 5) ? CNT_W : 5;

  logic [31:0]      key_mem [DEPTH];
  logic [15:0]      hgt_mem [DEPTH];
  logic [31:0]      rd_key;
  logic [15:0]      rd_hgt;
  logic [31:0]      key_reg;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [IDX_W-1:0] ptr;
  logic [IDX_W-1:0] raddr;
  logic [IDX_W-1:0] waddr;
  logic [31:0]      wkey;
  logic [15:0]      whgt;
  logic             wen;
  logic [KW-1:0]    k_ext;
  logic [KW-1:0]    c_ext;
  logic [CNT_W:0]   ptr_ext;
  logic [CNT_W:0]   cnt_ext;
  logic [31:0]      ptr_wide;
  logic [31:0]      cnt_wide;
  logic [31:0]      cnt_next_wide;

  assign k_ext         = KW'(item.from_end);
  assign c_ext         = KW'(count);
  assign ptr_ext       = (CNT_W + 1)'(ptr);
  assign cnt_ext       = (CNT_W + 1)'(count);
  assign ptr_wide      = 32'(ptr);
  assign cnt_wide      = 32'(count);
  assign cnt_next_wide = 32'(count_next);

  assign st.count_zero    = (count == '0);
  assign st.full          = (count == CNT_W'(DEPTH));
  assign st.match         = (rd_key == key_reg);
  assign st.ptr_last      = ((ptr_ext + 1'b1) >= cnt_ext);
  assign st.ptr_next_last = ((ptr_ext + 2'd2) >= cnt_ext);

  always_comb begin
    unique case (dc.rd_sel)
      orl_pkg::RD_ZERO: raddr = '0;
      orl_pkg::RD_KTH:  raddr = (k_ext >= c_ext) ? '0 : IDX_W'(c_ext - k_ext);
      orl_pkg::RD_MID:  raddr = IDX_W'(count >> 1);
      orl_pkg::RD_PTR1: raddr = ptr + 1'b1;
      orl_pkg::RD_PTR2: raddr = ptr + 2'd2;
      default:          raddr = '0;
    endcase
  end

  always_comb begin
    count_next = count;
    if (dc.cnt_clr) begin
      count_next = '0;
    end else if (dc.cnt_inc) begin
      count_next = count + 1'b1;
    end else if (dc.cnt_dec) begin
      count_next = count - 1'b1;
    end
  end

  assign wen   = dc.write_tail | dc.shift_wr;
  assign waddr = dc.write_tail ? IDX_W'(count) : ptr;
  assign wkey  = dc.write_tail ? item.key : rd_key;
  assign whgt  = dc.write_tail ? item.height_in : rd_hgt;

  // record memories, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wen) begin
      key_mem[waddr] <= wkey;
      hgt_mem[waddr] <= whgt;
    end
    rd_key <= key_mem[raddr];
    rd_hgt <= hgt_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (dc.capture) begin
      key_reg <= item.key;
    end
    unique case (dc.ptr_op)
      orl_pkg::PTR_LOAD: ptr <= raddr;
      orl_pkg::PTR_INC:  ptr <= ptr + 1'b1;
      default:           ptr <= ptr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (dc.emit == orl_pkg::EM_BLANK) || (dc.emit == orl_pkg::EM_NEW) ||
                      (dc.emit == orl_pkg::EM_READ) || (dc.emit == orl_pkg::EM_FINISH);
    end
  end

  always_ff @(posedge clk) begin
    case (dc.emit)
      orl_pkg::EM_BLANK: begin
        result.rec_key    <= '0;
        result.rec_height <= '0;
        result.rec_index  <= '0;
        result.list_count <= cnt_next_wide[4:0];
        result.status     <= dc.status;
        result.last       <= dc.last;
      end
      orl_pkg::EM_NEW: begin
        result.rec_key    <= item.key;
        result.rec_height <= item.height_in;
        result.rec_index  <= cnt_wide[3:0];
        result.list_count <= cnt_next_wide[4:0];
        result.status     <= dc.status;
        result.last       <= dc.last;
      end
      orl_pkg::EM_READ: begin
        result.rec_key    <= rd_key;
        result.rec_height <= rd_hgt;
        result.rec_index  <= ptr_wide[3:0];
        result.list_count <= cnt_next_wide[4:0];
        result.status     <= dc.status;
        result.last       <= dc.last;
      end
      orl_pkg::EM_SAVE: begin
        result.rec_key    <= rd_key;
        result.rec_height <= rd_hgt;
        result.rec_index  <= ptr_wide[3:0];
      end
      orl_pkg::EM_FINISH: begin
        result.list_count <= cnt_next_wide[4:0];
        result.status     <= dc.status;
        result.last       <= dc.last;
      end
      default: begin
        result <= result;
      end
    endcase
  end

endmodule

// ===== rtl/core/orl_ctrl.sv =====
// orl_ctrl: command sequencer for the ordered record list
// decodes accepted commands and steps scan, shift and view through orl_datapath
// depends on orl_pkg
module orl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  orl_pkg::item_t    item,
  input  orl_pkg::dp_stat_t st,
  output logic              busy,
  output orl_pkg::dp_cmd_t  dc
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_RD    = 5'b00010,
    S_VIEW  = 5'b00100,
    S_SCAN  = 5'b01000,
    S_SHIFT = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    dc         = '0;
    dc.rd_sel  = orl_pkg::RD_ZERO;
    dc.ptr_op  = orl_pkg::PTR_HOLD;
    dc.emit    = orl_pkg::EM_NONE;
    dc.status  = orl_pkg::ST_OK;
    dc.last    = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          dc.emit = orl_pkg::EM_BLANK;
          unique case (item.cmd)
            orl_pkg::CMD_APPEND: begin
              if (st.full) begin
                dc.status = orl_pkg::ST_FULL;
              end else begin
                dc.write_tail = 1'b1;
                dc.cnt_inc    = 1'b1;
                dc.emit       = orl_pkg::EM_NEW;
              end
            end
            orl_pkg::CMD_DELETE: begin
              if (st.count_zero) begin
                dc.status = orl_pkg::ST_EMPTY;
              end else begin
                dc.capture = 1'b1;
                dc.ptr_op  = orl_pkg::PTR_LOAD;
                dc.emit    = orl_pkg::EM_NONE;
                state_next = S_SCAN;
              end
            end
            orl_pkg::CMD_CLEAR: begin
              if (st.count_zero) begin
                dc.status = orl_pkg::ST_EMPTY;
              end else begin
                dc.cnt_clr = 1'b1;
              end
            end
            orl_pkg::CMD_KTH: begin
              if (st.count_zero) begin
                dc.status = orl_pkg::ST_EMPTY;
              end else if (item.from_end == '0) begin
                dc.status = orl_pkg::ST_BAD_POS;
              end else begin
                dc.rd_sel  = orl_pkg::RD_KTH;
                dc.ptr_op  = orl_pkg::PTR_LOAD;
                dc.emit    = orl_pkg::EM_NONE;
                state_next = S_RD;
              end
            end
            orl_pkg::CMD_MIDDLE: begin
              if (st.count_zero) begin
                dc.status = orl_pkg::ST_EMPTY;
              end else begin
                dc.rd_sel  = orl_pkg::RD_MID;
                dc.ptr_op  = orl_pkg::PTR_LOAD;
                dc.emit    = orl_pkg::EM_NONE;
                state_next = S_RD;
              end
            end
            orl_pkg::CMD_VIEW: begin
              if (st.count_zero) begin
                dc.status = orl_pkg::ST_EMPTY;
              end else begin
                dc.ptr_op  = orl_pkg::PTR_LOAD;
                dc.emit    = orl_pkg::EM_NONE;
                state_next = S_VIEW;
              end
            end
            default: begin
              dc.status = orl_pkg::ST_OK;
            end
          endcase
        end
      end
      S_RD: begin
        dc.emit    = orl_pkg::EM_READ;
        state_next = S_IDLE;
      end
      S_VIEW: begin
        dc.emit = orl_pkg::EM_READ;
        dc.last = st.ptr_last;
        if (st.ptr_last) begin
          state_next = S_IDLE;
        end else begin
          dc.rd_sel = orl_pkg::RD_PTR1;
          dc.ptr_op = orl_pkg::PTR_INC;
        end
      end
      S_SCAN: begin
        if (st.match) begin
          if (st.ptr_last) begin
            dc.cnt_dec = 1'b1;
            dc.emit    = orl_pkg::EM_READ;
            state_next = S_IDLE;
          end else begin
            dc.emit    = orl_pkg::EM_SAVE;
            dc.rd_sel  = orl_pkg::RD_PTR1;
            state_next = S_SHIFT;
          end
        end else if (st.ptr_last) begin
          dc.emit    = orl_pkg::EM_BLANK;
          dc.status  = orl_pkg::ST_NOT_FOUND;
          state_next = S_IDLE;
        end else begin
          dc.rd_sel = orl_pkg::RD_PTR1;
          dc.ptr_op = orl_pkg::PTR_INC;
        end
      end
      S_SHIFT: begin
        dc.shift_wr = 1'b1;
        if (st.ptr_next_last) begin
          dc.cnt_dec = 1'b1;
          dc.emit    = orl_pkg::EM_FINISH;
          state_next = S_IDLE;
        end else begin
          dc.rd_sel = orl_pkg::RD_PTR2;
          dc.ptr_op = orl_pkg::PTR_INC;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/ordered_record_list.sv =====
// ordered_record_list: top level of the ordered record list
// joins orl_ctrl and orl_datapath; depends on orl_pkg
//
// A command beat is taken at a clock edge with start high and busy low. Results
// come out one beat per cycle on result, marked by result_valid for exactly one
// cycle; result.last flags the final beat of a command. The receiver cannot
// hold results off, and none is needed: no beat is ever waiting on the sink.
// Append, clear, count and the errors found at acceptance give their result in
// the cycle after acceptance and leave busy low, so such commands can issue
// every cycle. Kth-from-end and middle read their record in S_RD and give one
// beat. View streams count beats, one per cycle. Delete scans one record per
// cycle up to the match and then moves each later record down one place per
// cycle. These rates follow from the record memory having one read and one
// write port with a registered read. Reset (rst, synchronous) empties the list
// and returns the sequencer to idle; stored records need no clearing since only
// entries below the count are ever read.
module ordered_record_list #(
  parameter int DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  orl_pkg::item_t   item,
  output logic             busy,
  output logic             result_valid,
  output orl_pkg::result_t result
);

  orl_pkg::dp_cmd_t  dc;
  orl_pkg::dp_stat_t st;

  orl_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .item  (item),
    .st    (st),
    .busy  (busy),
    .dc    (dc)
  );

  orl_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .dc           (dc),
    .st           (st),
    .result_valid (result_valid),
    .result       (result)
  );

  a_stream_continuous : assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |=> result_valid)
    else $error("view stream broke before its last beat");

  a_error_is_last : assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status != orl_pkg::ST_OK) |-> result.last)
    else $error("error status on a beat that is not last");

  a_done_emits : assert property (@(posedge clk) disable iff (rst)
    $fell(busy) && !$past(rst) |-> result_valid && result.last)
    else $error("sequencer went idle without a final beat");

endmodule

// ===== tb/tb_ordered_record_list.sv =====
// tb_ordered_record_list: self-checking bench for the ordered record list
// drives command beats, predicts each result beat from a local copy of the list
// depends on orl_pkg and ordered_record_list
module tb_ordered_record_list;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  localparam logic [2:0] CMD_UNUSED = 3'd7;
  localparam int RANDOM_TARGET = 230;
  localparam int STALL_LIMIT = 3000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  orl_pkg::item_t cmd_beat = '0;
  logic busy;
  logic result_valid;
  orl_pkg::result_t beat_out;

  ordered_record_list #(.DEPTH(DEPTH)) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .item(cmd_beat),
    .busy(busy),
    .result_valid(result_valid),
    .result(beat_out)
  );

  orl_pkg::item_t pending_cmds[$];
  orl_pkg::result_t expected_beats[$];
  logic [31:0] list_key[DEPTH];
  logic [15:0] list_height[DEPTH];
  int unsigned list_len = 0;
  logic [31:0] key_pool[8];

  int total_cmds = 0;
  int issued = 0;
  int accepted = 0;
  int beats_checked = 0;
  int mismatches = 0;
  int full_hits = 0;
  int stall_cycles = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic orl_pkg::result_t list_beat(logic [31:0] k, logic [15:0] h,
                                                 int unsigned idx, logic [2:0] st,
                                                 logic lst);
    orl_pkg::result_t r;
    r.rec_key = k;
    r.rec_height = h;
    r.rec_index = idx[3:0];
    r.list_count = list_len[4:0];
    r.status = st;
    r.last = lst;
    return r;
  endfunction

  task automatic apply_command(input orl_pkg::item_t c);
    int unsigned idx;
    int hit;
    logic [31:0] rk;
    logic [15:0] rh;
    hit = -1;
    case (c.cmd)
      orl_pkg::CMD_APPEND: begin
        if (list_len >= DEPTH) begin
          full_hits++;
          expected_beats.push_back(list_beat('0, '0, 0, orl_pkg::ST_FULL, 1'b1));
        end else begin
          list_key[list_len] = c.key;
          list_height[list_len] = c.height_in;
          list_len++;
          expected_beats.push_back(list_beat(c.key, c.height_in, list_len - 1,
                                             orl_pkg::ST_OK, 1'b1));
        end
      end
      orl_pkg::CMD_DELETE: begin
        if (list_len == 0) begin
          expected_beats.push_back(list_beat('0, '0, 0, orl_pkg::ST_EMPTY, 1'b1));
        end else begin
          for (int i = 0; i < list_len; i++)
            if (hit < 0 && list_key[i] == c.key) hit = i;
          if (hit < 0) begin
            expected_beats.push_back(list_beat('0, '0, 0, orl_pkg::ST_NOT_FOUND, 1'b1));
          end else begin
            rk = list_key[hit];
            rh = list_height[hit];
            for (int j = hit; j + 1 < list_len; j++) begin
              list_key[j] = list_key[j + 1];
              list_height[j] = list_height[j + 1];
            end
            list_len--;
            expected_beats.push_back(list_beat(rk, rh, hit, orl_pkg::ST_OK, 1'b1));
          end
        end
      end
      orl_pkg::CMD_CLEAR: begin
        if (list_len == 0) begin
          expected_beats.push_back(list_beat('0, '0, 0, orl_pkg::ST_EMPTY, 1'b1));
        end else begin
          list_len = 0;
          expected_beats.push_back(list_beat('0, '0, 0, orl_pkg::ST_OK, 1'b1));
        end
      end
      orl_pkg::CMD_KTH: begin
        if (list_len == 0) begin
          expected_beats.push_back(list_beat('0, '0, 0, orl_pkg::ST_EMPTY, 1'b1));
        end else if (c.from_end == 0) begin
          expected_beats.push_back(list_beat('0, '0, 0, orl_pkg::ST_BAD_POS, 1'b1));
        end else begin
          idx = (c.from_end >= list_len) ? 0 : list_len - c.from_end;
          expected_beats.push_back(list_beat(list_key[idx], list_height[idx], idx,
                                             orl_pkg::ST_OK, 1'b1));
        end
      end
      orl_pkg::CMD_MIDDLE: begin
        if (list_len == 0) begin
          expected_beats.push_back(list_beat('0, '0, 0, orl_pkg::ST_EMPTY, 1'b1));
        end else begin
          idx = list_len / 2;
          expected_beats.push_back(list_beat(list_key[idx], list_height[idx], idx,
                                             orl_pkg::ST_OK, 1'b1));
        end
      end
      orl_pkg::CMD_VIEW: begin
        if (list_len == 0) begin
          expected_beats.push_back(list_beat('0, '0, 0, orl_pkg::ST_EMPTY, 1'b1));
        end else begin
          for (int i = 0; i < list_len; i++)
            expected_beats.push_back(list_beat(list_key[i], list_height[i], i,
                                               orl_pkg::ST_OK, i + 1 == list_len));
        end
      end
      default: begin
        expected_beats.push_back(list_beat('0, '0, 0, orl_pkg::ST_OK, 1'b1));
      end
    endcase
  endtask

  task automatic queue_cmd(logic [2:0] c, logic [31:0] k, logic [15:0] h, logic [4:0] p);
    orl_pkg::item_t it;
    it.cmd = c;
    it.key = k;
    it.height_in = h;
    it.from_end = p;
    pending_cmds.push_back(it);
  endtask

  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  function automatic logic [4:0] pick_pos();
    if ($urandom_range(0, 99) < 70) return 5'($urandom_range(1, 17));
    return 5'($urandom_range(0, 31));
  endfunction

  function automatic bit sender_idles();
    int pct;
    if (issued < total_cmds / 3) pct = 9;
    else if (issued < 2 * total_cmds / 3) pct = 81;
    else pct = 0;
    return $urandom_range(0, 99) < pct;
  endfunction

  // driver: hold start until the beat is taken
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        apply_command(cmd_beat);
        accepted++;
      end
      if (!start || !busy) begin
        if (pending_cmds.size() > 0 && !sender_idles()) begin
          cmd_beat <= pending_cmds.pop_front();
          issued++;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    orl_pkg::result_t want;
    if (!rst && result_valid) begin
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected beat key=%0d h=%0d idx=%0d cnt=%0d st=%0d last=%0b",
                   $realtime, beat_out.rec_key, beat_out.rec_height, beat_out.rec_index,
                   beat_out.list_count, beat_out.status, beat_out.last);
      end else begin
        want = expected_beats.pop_front();
        beats_checked++;
        if (beat_out.rec_key !== want.rec_key || beat_out.rec_height !== want.rec_height ||
            beat_out.rec_index !== want.rec_index || beat_out.list_count !== want.list_count ||
            beat_out.status !== want.status || beat_out.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: mismatch exp key=%0d h=%0d idx=%0d cnt=%0d st=%0d last=%0b",
                     $realtime, want.rec_key, want.rec_height, want.rec_index,
                     want.list_count, want.status, want.last);
            $display("    got key=%0d h=%0d idx=%0d cnt=%0d st=%0d last=%0b",
                     beat_out.rec_key, beat_out.rec_height, beat_out.rec_index,
                     beat_out.list_count, beat_out.status, beat_out.last);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int n;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    for (int i = 2; i < 8; i++) key_pool[i] = 32'($urandom_range(0, 20)) - 32'd10;

    // empty-list cases and the unused code
    queue_cmd(orl_pkg::CMD_COUNT, '0, '0, '0);
    queue_cmd(orl_pkg::CMD_DELETE, '0, '0, '0);
    queue_cmd(orl_pkg::CMD_CLEAR, '0, '0, '0);
    queue_cmd(orl_pkg::CMD_KTH, '0, '0, 5'd1);
    queue_cmd(orl_pkg::CMD_MIDDLE, '0, '0, '0);
    queue_cmd(orl_pkg::CMD_VIEW, '0, '0, '0);
    queue_cmd(CMD_UNUSED, 32'hffff_ffff, 16'hffff, 5'd31);
    // extreme keys and heights, one duplicate key
    queue_cmd(orl_pkg::CMD_APPEND, 32'h8000_0000, 16'h0000, '0);
    queue_cmd(orl_pkg::CMD_APPEND, 32'h7fff_ffff, 16'hffff, '0);
    queue_cmd(orl_pkg::CMD_APPEND, 32'h0000_0000, 16'h0001, '0);
    queue_cmd(orl_pkg::CMD_APPEND, 32'h8000_0000, 16'h1234, '0);
    queue_cmd(orl_pkg::CMD_APPEND, 32'hffff_ffff, 16'h8000, '0);
    queue_cmd(orl_pkg::CMD_KTH, '0, '0, 5'd0);
    queue_cmd(orl_pkg::CMD_KTH, '0, '0, 5'd1);
    queue_cmd(orl_pkg::CMD_KTH, '0, '0, 5'd16);
    queue_cmd(orl_pkg::CMD_KTH, '0, '0, 5'd31);
    queue_cmd(orl_pkg::CMD_MIDDLE, '0, '0, '0);
    queue_cmd(orl_pkg::CMD_VIEW, '0, '0, '0);
    queue_cmd(orl_pkg::CMD_DELETE, 32'h8000_0000, '0, '0);
    queue_cmd(orl_pkg::CMD_DELETE, 32'd12345, '0, '0);
    queue_cmd(orl_pkg::CMD_DELETE, 32'hffff_ffff, '0, '0);
    queue_cmd(orl_pkg::CMD_VIEW, '0, '0, '0);
    queue_cmd(orl_pkg::CMD_CLEAR, '0, '0, '0);
    queue_cmd(orl_pkg::CMD_VIEW, '0, '0, '0);

    while (pending_cmds.size() < RANDOM_TARGET) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: begin
          n = $urandom_range(3, 18);
          repeat (n) queue_cmd(orl_pkg::CMD_APPEND, pick_key(), 16'($urandom), 5'($urandom));
        end
        6, 7, 8, 9, 10, 11: begin
          n = $urandom_range(2, 6);
          repeat (n) begin
            case ($urandom_range(0, 4))
              0, 1: queue_cmd(orl_pkg::CMD_KTH, pick_key(), 16'($urandom), pick_pos());
              2: queue_cmd(orl_pkg::CMD_MIDDLE, pick_key(), 16'($urandom), pick_pos());
              3: queue_cmd(orl_pkg::CMD_COUNT, pick_key(), 16'($urandom), pick_pos());
              default: queue_cmd(orl_pkg::CMD_VIEW, pick_key(), 16'($urandom), pick_pos());
            endcase
          end
        end
        12, 13, 14, 15, 16: begin
          n = $urandom_range(1, 6);
          repeat (n) queue_cmd(orl_pkg::CMD_DELETE, pick_key(), 16'($urandom), pick_pos());
        end
        default: begin
          n = $urandom_range(1, 4);
          repeat (n) queue_cmd(3'($urandom_range(0, 7)), $urandom, 16'($urandom),
                               5'($urandom_range(0, 31)));
        end
      endcase
    end
    total_cmds = pending_cmds.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() > 0 || start || expected_beats.size() > 0) @(posedge clk);
    repeat (2 * DEPTH + 8) @(posedge clk);

    $display("ran %0d commands in three pacing phases, checked %0d result beats", accepted,
             beats_checked);
    $display("list-full hits: %0d, mismatches: %0d", full_hits, mismatches);
    if (mismatches == 0 && expected_beats.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
